// ----- rtl/dmsrt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Search result table package
// Shared sizes, command and kind codes, payload and control types.
// ---------------------------------------------------------------------------
package dmsrt_pkg;

   localparam int TABLE_ENTRIES = 4096;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CSR_W         = 13;
   localparam int DIV_STEPS     = 32;

   localparam logic [2:0] CMD_PROBE_EXACT   = 3'd0;
   localparam logic [2:0] CMD_PROBE_BOUNDED = 3'd1;
   localparam logic [2:0] CMD_SAVE_EXACT    = 3'd2;
   localparam logic [2:0] CMD_SAVE_FULL     = 3'd3;
   localparam logic [2:0] CMD_CLEAR         = 3'd4;

   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_EXACT = 2'd1;
   localparam logic [1:0] KIND_UPPER = 2'd2;
   localparam logic [1:0] KIND_LOWER = 2'd3;

   localparam logic [7:0] CLEARED_MOVE = 8'hFF;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [63:0]        key;
      logic [7:0]         depth;
      logic signed [31:0] alpha;
      logic signed [31:0] beta;
      logic signed [15:0] value;
      logic [7:0]         chosen_move;
      logic [1:0]         kind;
   } req_payload_type;

   typedef struct packed {
      logic               hit;
      logic [63:0]        slot_key;
      logic [7:0]         slot_depth;
      logic signed [15:0] slot_value;
      logic [7:0]         slot_move;
      logic [1:0]         slot_kind;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [7:0]         depth;
      logic signed [15:0] value;
      logic [1:0]         kind;
   } entry_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIVIDE,
      ST_ACCESS,
      ST_WIPE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic mem_read;
      logic mem_write;
      logic wipe_step;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       div_last;
      logic       wipe_last;
      logic [2:0] cmd;
   } dp_status_type;

endpackage

// ----- rtl/dmsrt_divider.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot index divider
// Restoring remainder unit, one dividend bit per cycle while step is high.
// ---------------------------------------------------------------------------
module dmsrt_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        step,
   input  logic [31:0]                 dividend,
   input  logic [dmsrt_pkg::CSR_W-1:0] divisor,
   output logic [dmsrt_pkg::IDX_W-1:0] remainder,
   output logic                        last
);
   import dmsrt_pkg::*;

   localparam int COUNT_W = $clog2(DIV_STEPS);

   logic [31:0]        dividend_ff;
   logic [IDX_W-1:0]   rem_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [IDX_W:0]     trial;
   logic [IDX_W:0]     diff;

   assign trial = {rem_ff, dividend_ff[31]};
   assign diff  = trial - (IDX_W+1)'(divisor);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dividend_ff <= dividend;
         rem_ff      <= '0;
      end else if (step) begin
         dividend_ff <= {dividend_ff[30:0], 1'b0};
         // subtract when the shifted remainder reaches the divisor
         if (trial >= (IDX_W+1)'(divisor)) begin
            rem_ff <= diff[IDX_W-1:0];
         end else begin
            rem_ff <= trial[IDX_W-1:0];
         end
      end
   end

   assign remainder = rem_ff;
   assign last      = (count_ff == COUNT_W'(DIV_STEPS - 1));

endmodule

// ----- rtl/dmsrt_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Search result table datapath
// Request capture, index divider, slot memories, hit check, result register.
// ---------------------------------------------------------------------------
module dmsrt_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  dmsrt_pkg::ctrl_cmd_type     ctrl,
   output dmsrt_pkg::dp_status_type    status,
   input  dmsrt_pkg::req_payload_type  req_payload,
   output dmsrt_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [dmsrt_pkg::CSR_W-1:0] csr_wr_data
);
   import dmsrt_pkg::*;

   req_payload_type  req_ff;
   rsp_payload_type  rsp_ff;
   rsp_payload_type  rsp_in;
   logic [CSR_W-1:0] entries_ff;
   logic [CSR_W-1:0] divisor;
   logic [IDX_W-1:0] index;
   logic [IDX_W-1:0] wipe_cnt_ff;
   logic [IDX_W-1:0] addr;
   logic             div_last;

   entry_type        entry_mem_ff [TABLE_ENTRIES];
   logic [7:0]       move_mem_ff  [TABLE_ENTRIES];
   entry_type        rd_entry_ff;
   logic [7:0]       rd_move_ff;
   entry_type        wr_entry;
   logic [7:0]       wr_move;
   logic             move_we;

   logic             key_match;
   logic             hit;
   logic signed [31:0] stored_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CSR_W'(TABLE_ENTRIES);
      end else if (csr_wr_en) begin
         entries_ff <= csr_wr_data;
      end
   end

   // treat zero as one, clamp to the table size
   always_comb begin
      priority if (entries_ff == '0) begin
         divisor = CSR_W'(1);
      end else if (entries_ff > CSR_W'(TABLE_ENTRIES)) begin
         divisor = CSR_W'(TABLE_ENTRIES);
      end else begin
         divisor = entries_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         req_ff <= req_payload;
      end
   end

   dmsrt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .load      (ctrl.capture),
      .step      (ctrl.div_step),
      .dividend  (req_payload.key[63:32]),
      .divisor   (divisor),
      .remainder (index),
      .last      (div_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_cnt_ff <= '0;
      end else if (ctrl.wipe_step) begin
         wipe_cnt_ff <= wipe_cnt_ff + 1'b1;
      end
   end

   assign addr = ctrl.wipe_step ? wipe_cnt_ff : index;

   always_comb begin
      if (ctrl.wipe_step) begin
         wr_entry = '{key: '0, depth: '0, value: '0, kind: KIND_EMPTY};
         wr_move  = CLEARED_MOVE;
         move_we  = 1'b1;
      end else begin
         wr_entry.key   = req_ff.key;
         wr_entry.depth = req_ff.depth;
         wr_entry.value = req_ff.value;
         wr_entry.kind  = (req_ff.cmd == CMD_SAVE_FULL) ? req_ff.kind : KIND_EXACT;
         wr_move        = req_ff.chosen_move;
         // exact save keeps the old move
         move_we        = ctrl.mem_write && (req_ff.cmd == CMD_SAVE_FULL);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mem_write || ctrl.wipe_step) begin
         entry_mem_ff[addr] <= wr_entry;
      end
      if (move_we) begin
         move_mem_ff[addr] <= wr_move;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mem_read) begin
         rd_entry_ff <= entry_mem_ff[index];
         rd_move_ff  <= move_mem_ff[index];
      end
   end

   assign stored_value = {{16{rd_entry_ff.value[15]}}, rd_entry_ff.value};
   assign key_match    = (rd_entry_ff.key == req_ff.key) && (rd_entry_ff.depth >= req_ff.depth);

   always_comb begin
      hit = 1'b0;
      if (key_match) begin
         priority if (rd_entry_ff.kind == KIND_EXACT) begin
            hit = 1'b1;
         end else if (req_ff.cmd == CMD_PROBE_BOUNDED && rd_entry_ff.kind == KIND_UPPER) begin
            hit = (stored_value <= req_ff.alpha);
         end else if (req_ff.cmd == CMD_PROBE_BOUNDED && rd_entry_ff.kind == KIND_LOWER) begin
            hit = (stored_value >= req_ff.beta);
         end else begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (req_ff.cmd)
         CMD_PROBE_EXACT, CMD_PROBE_BOUNDED: begin
            rsp_in.hit        = hit;
            rsp_in.slot_key   = rd_entry_ff.key;
            rsp_in.slot_depth = rd_entry_ff.depth;
            rsp_in.slot_value = rd_entry_ff.value;
            rsp_in.slot_move  = rd_move_ff;
            rsp_in.slot_kind  = rd_entry_ff.kind;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload      = rsp_ff;
   assign status.div_last  = div_last;
   assign status.wipe_last = (wipe_cnt_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign status.cmd       = req_ff.cmd;

endmodule

// ----- rtl/dmsrt_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Search result table controller
// Sequences capture, index division, slot access, table sweep and result.
// ---------------------------------------------------------------------------
module dmsrt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  dmsrt_pkg::dp_status_type status,
   output dmsrt_pkg::ctrl_cmd_type  ctrl
);
   import dmsrt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_INIT: begin
            ctrl.wipe_step = 1'b1;
            if (status.wipe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            ctrl.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            unique case (status.cmd)
               CMD_PROBE_EXACT, CMD_PROBE_BOUNDED: begin
                  ctrl.mem_read = 1'b1;
                  state_in      = ST_FINISH;
               end
               CMD_SAVE_EXACT, CMD_SAVE_FULL: begin
                  ctrl.mem_write = 1'b1;
                  state_in       = ST_FINISH;
               end
               CMD_CLEAR: begin
                  state_in = ST_WIPE;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_WIPE: begin
            ctrl.wipe_step = 1'b1;
            if (status.wipe_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register can take a new transaction
            if (out_free) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/direct_mapped_search_result_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Direct-mapped search result table
// Always-replace table of search results indexed by the upper key half modulo entry count.
// ---------------------------------------------------------------------------
// Sequence: probe, save and unknown commands go from the accepted transaction
//   through the divider steps, the slot memory access and the result load.
// Clear adds a sweep of all slot memories, one slot per cycle.
// One transaction at a time: the next is taken only after the result is loaded; a held result delays that.
// Reset: synchronous; a sweep of all slots follows, req_stall stays high meanwhile.
module direct_mapped_search_result_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  dmsrt_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output dmsrt_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [dmsrt_pkg::CSR_W-1:0] csr_wr_data
);
   import dmsrt_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   dmsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   dmsrt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

// ----- rtl/dmsrt_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Search result table checker
// Port-level properties of the table, bound to the top level.
// ---------------------------------------------------------------------------
module dmsrt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input dmsrt_pkg::rsp_payload_type rsp_payload
);
   import dmsrt_pkg::*;

   logic req_taken;

   assign req_taken = req_valid && !req_stall;

   // the table sweep after reset refuses transactions
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_stall)
      else $error("request taken during post-reset sweep");

   // one transaction at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset) req_taken |=> req_stall)
      else $error("second transaction accepted while busy");

   // an empty slot never hits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |-> rsp_payload.slot_kind != KIND_EMPTY)
      else $error("hit reported on an empty slot");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // no result follows directly on an accept
   assert property (@(posedge clock) disable iff (reset)
      req_taken && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after accept");

endmodule

bind direct_mapped_search_result_table dmsrt_checker u_dmsrt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
